[hw/rtl/dns_response_field_parser_unit_assert.svh]
// ----------------------------------------------------------------------------
// DNS response field parser assertion macros
// Concurrent assertion wrappers used by the parser step module.
// ----------------------------------------------------------------------------
`ifndef DNS_RESPONSE_FIELD_PARSER_UNIT_ASSERT_SVH
`define DNS_RESPONSE_FIELD_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define DNSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DNSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dnsp_pkg.sv]
// ----------------------------------------------------------------------------
// DNS response field parser package
// Transaction types, field codes and phase encoding.
// ----------------------------------------------------------------------------
package dnsp_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [31:0] field_value;
        logic        final_result;
    } field_item_t;

    localparam logic [4:0] FC_ID        = 5'd0;
    localparam logic [4:0] FC_NAME_CHAR = 5'd6;
    localparam logic [4:0] FC_LABEL_END = 5'd7;
    localparam logic [4:0] FC_QTYPE     = 5'd8;
    localparam logic [4:0] FC_QCLASS    = 5'd9;
    localparam logic [4:0] FC_ATYPE     = 5'd10;
    localparam logic [4:0] FC_ACLASS    = 5'd11;
    localparam logic [4:0] FC_TTL       = 5'd12;
    localparam logic [4:0] FC_RDLENGTH  = 5'd13;
    localparam logic [4:0] FC_RDATA     = 5'd14;
    localparam logic [4:0] FC_TRUNCATED = 5'd15;
    localparam logic [4:0] FC_OVERLONG  = 5'd16;

    localparam logic [2:0] HDR_ANCOUNT  = 3'd3;
    localparam logic [2:0] HDR_LAST     = 3'd5;

    localparam logic [2:0] LEN_SHORT    = 3'd2;
    localparam logic [2:0] LEN_LONG     = 3'd4;

    localparam logic [7:0]  PTR_MASK    = 8'hC0;
    localparam logic [15:0] TYPE_A      = 16'd1;
    localparam logic [15:0] TYPE_AAAA   = 16'd28;
    localparam logic [4:0]  RDATA_A     = 5'd4;
    localparam logic [4:0]  RDATA_AAAA  = 5'd16;

    typedef enum logic [1:0] {
        AT_OTHER = 2'b00,
        AT_A     = 2'b01,
        AT_AAAA  = 2'b10
    } atype_class_t;

    typedef enum logic [14:0] {
        PH_HEADER   = 15'b000000000000001,
        PH_QN_FIRST = 15'b000000000000010,
        PH_QN_LABEL = 15'b000000000000100,
        PH_QN_NEXT  = 15'b000000000001000,
        PH_QTYPE    = 15'b000000000010000,
        PH_QCLASS   = 15'b000000000100000,
        PH_AN_FIRST = 15'b000000001000000,
        PH_AN_PTR   = 15'b000000010000000,
        PH_AN_SKIP  = 15'b000000100000000,
        PH_ATYPE    = 15'b000001000000000,
        PH_ACLASS   = 15'b000010000000000,
        PH_TTL      = 15'b000100000000000,
        PH_RDLEN    = 15'b001000000000000,
        PH_RDATA    = 15'b010000000000000,
        PH_IDLE     = 15'b100000000000000
    } phase_t;

endpackage

[hw/rtl/dnsp_if.sv]
// ----------------------------------------------------------------------------
// DNS response field parser channels
// Valid/ready channels for message bytes and field results.
// ----------------------------------------------------------------------------
interface dnsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       end_of_message;

    modport source (output valid, output msg_byte, output end_of_message, input ready);
    modport sink   (input valid, input msg_byte, input end_of_message, output ready);
endinterface

interface dnsp_field_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_code;
    logic [31:0] field_value;
    logic        final_result;

    modport source (output valid, output field_code, output field_value,
                    output final_result, input ready);
    modport sink   (input valid, input field_code, input field_value,
                    input final_result, output ready);
endinterface

[hw/rtl/dnsp_in_stage.sv]
// ----------------------------------------------------------------------------
// DNS parser input stage
// Registers one message byte transaction ahead of the parse step.
// ----------------------------------------------------------------------------
module dnsp_in_stage
    import dnsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dnsp_byte_if.sink   byte_in,
    input  logic        take,
    output logic        item_valid,
    output byte_item_t  item
);

    logic       valid_reg;
    byte_item_t item_reg;

    assign byte_in.ready = !valid_reg || take;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            item_reg <= '{msg_byte: byte_in.msg_byte,
                          end_of_message: byte_in.end_of_message};
        end
    end

endmodule

[hw/rtl/dnsp_step.sv]
// ----------------------------------------------------------------------------
// DNS parser step
// Parse state, per-byte field decode and the result register.
// ----------------------------------------------------------------------------
`include "dns_response_field_parser_unit_assert.svh"

module dnsp_step
    import dnsp_pkg::*;
#(
    parameter int MAX_MESSAGE = 512
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  byte_item_t   item,
    output logic         take,
    dnsp_field_if.source field_out
);

    localparam int CNT_W = $clog2(MAX_MESSAGE + 1);

    phase_t       phase_reg, phase_next;
    logic [2:0]   idx_reg, idx_next;
    logic [31:0]  acc_reg, acc_next;
    logic [2:0]   hdr_reg, hdr_next;
    logic [7:0]   label_reg, label_next;
    logic         answers_reg, answers_next;
    atype_class_t atype_reg, atype_next;
    logic [4:0]   rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic         out_valid_reg;
    field_item_t  out_reg;

    logic [31:0]  acc_shift;
    logic [2:0]   idx_inc;
    logic [2:0]   need;
    logic         gdone;
    logic         gather_ph;
    logic         over;
    logic [7:0]   b;
    logic         res_valid;
    field_item_t  res;

    assign take = item_valid && (!out_valid_reg || field_out.ready);
    assign b    = item.msg_byte;

    assign acc_shift = {acc_reg[23:0], b};
    assign idx_inc   = idx_reg + 3'd1;
    assign need      = (phase_reg == PH_TTL) ? LEN_LONG : LEN_SHORT;
    assign gdone     = idx_inc >= need;
    assign over      = cnt_reg >= CNT_W'(MAX_MESSAGE);
    assign gather_ph = (phase_reg == PH_HEADER) || (phase_reg == PH_QTYPE) ||
                       (phase_reg == PH_QCLASS) || (phase_reg == PH_ATYPE) ||
                       (phase_reg == PH_ACLASS) || (phase_reg == PH_TTL) ||
                       (phase_reg == PH_RDLEN);

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        hdr_next     = hdr_reg;
        label_next   = label_reg;
        answers_next = answers_reg;
        atype_next   = atype_reg;
        rd_next      = rd_reg;
        cnt_next     = cnt_reg;
        res_valid    = 1'b0;
        res          = '{field_code: FC_ID, field_value: 32'd0, final_result: 1'b0};

        if (phase_reg != PH_IDLE)
        begin
            if (over)
            begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res        = '{field_code: FC_OVERLONG, field_value: 32'd0,
                               final_result: 1'b1};
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (gather_ph)
                begin
                    acc_next = gdone ? 32'd0 : acc_shift;
                    idx_next = gdone ? 3'd0 : idx_inc;
                end
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (gdone)
                        begin
                            if (hdr_reg == HDR_ANCOUNT)
                            begin
                                answers_next = (acc_shift[15:0] != 16'd0);
                            end
                            if (hdr_reg == HDR_LAST)
                            begin
                                hdr_next   = 3'd0;
                                phase_next = PH_QN_FIRST;
                            end
                            else
                            begin
                                hdr_next = hdr_reg + 3'd1;
                            end
                            res_valid = 1'b1;
                            res = '{field_code: FC_ID + 5'(hdr_reg), field_value: acc_shift,
                                    final_result: 1'b0};
                        end
                    end
                    PH_QN_FIRST, PH_QN_NEXT:
                    begin
                        if (b == 8'd0)
                        begin
                            phase_next = PH_QTYPE;
                        end
                        else
                        begin
                            label_next = b;
                            phase_next = PH_QN_LABEL;
                        end
                        if (phase_reg == PH_QN_NEXT)
                        begin
                            res_valid = 1'b1;
                            res = '{field_code: FC_LABEL_END, field_value: 32'd0,
                                    final_result: 1'b0};
                        end
                    end
                    PH_QN_LABEL:
                    begin
                        label_next = label_reg - 8'd1;
                        if (label_reg == 8'd1)
                        begin
                            phase_next = PH_QN_NEXT;
                        end
                        res_valid = 1'b1;
                        res = '{field_code: FC_NAME_CHAR, field_value: 32'(b),
                                final_result: 1'b0};
                    end
                    PH_QTYPE:
                    begin
                        if (gdone)
                        begin
                            phase_next = PH_QCLASS;
                            res_valid  = 1'b1;
                            res = '{field_code: FC_QTYPE, field_value: acc_shift,
                                    final_result: 1'b0};
                        end
                    end
                    PH_QCLASS:
                    begin
                        if (gdone)
                        begin
                            phase_next = answers_reg ? PH_AN_FIRST : PH_IDLE;
                            res_valid  = 1'b1;
                            res = '{field_code: FC_QCLASS, field_value: acc_shift,
                                    final_result: !answers_reg};
                        end
                    end
                    PH_AN_FIRST:
                    begin
                        if ((b & PTR_MASK) == PTR_MASK)
                        begin
                            phase_next = PH_AN_PTR;
                        end
                        else if (b == 8'd0)
                        begin
                            phase_next = PH_ATYPE;
                        end
                        else
                        begin
                            phase_next = PH_AN_SKIP;
                        end
                    end
                    PH_AN_PTR:
                    begin
                        phase_next = PH_ATYPE;
                    end
                    PH_AN_SKIP:
                    begin
                        if (b == 8'd0)
                        begin
                            phase_next = PH_ATYPE;
                        end
                    end
                    PH_ATYPE:
                    begin
                        if (gdone)
                        begin
                            if (acc_shift[15:0] == TYPE_A)
                            begin
                                atype_next = AT_A;
                            end
                            else if (acc_shift[15:0] == TYPE_AAAA)
                            begin
                                atype_next = AT_AAAA;
                            end
                            else
                            begin
                                atype_next = AT_OTHER;
                            end
                            phase_next = PH_ACLASS;
                            res_valid  = 1'b1;
                            res = '{field_code: FC_ATYPE, field_value: acc_shift,
                                    final_result: 1'b0};
                        end
                    end
                    PH_ACLASS:
                    begin
                        if (gdone)
                        begin
                            phase_next = PH_TTL;
                            res_valid  = 1'b1;
                            res = '{field_code: FC_ACLASS, field_value: acc_shift,
                                    final_result: 1'b0};
                        end
                    end
                    PH_TTL:
                    begin
                        if (gdone)
                        begin
                            phase_next = PH_RDLEN;
                            res_valid  = 1'b1;
                            res = '{field_code: FC_TTL, field_value: acc_shift,
                                    final_result: 1'b0};
                        end
                    end
                    PH_RDLEN:
                    begin
                        if (gdone)
                        begin
                            case (atype_reg)
                                AT_A:
                                begin
                                    rd_next    = RDATA_A;
                                    phase_next = PH_RDATA;
                                end
                                AT_AAAA:
                                begin
                                    rd_next    = RDATA_AAAA;
                                    phase_next = PH_RDATA;
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                end
                            endcase
                            res_valid = 1'b1;
                            res = '{field_code: FC_RDLENGTH, field_value: acc_shift,
                                    final_result: (atype_reg == AT_OTHER)};
                        end
                    end
                    PH_RDATA:
                    begin
                        rd_next = rd_reg - 5'd1;
                        if (rd_reg == 5'd1)
                        begin
                            phase_next = PH_IDLE;
                        end
                        res_valid = 1'b1;
                        res = '{field_code: FC_RDATA, field_value: 32'(b),
                                final_result: (rd_reg == 5'd1)};
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
                if (item.end_of_message && (phase_next != PH_IDLE))
                begin
                    res_valid = 1'b1;
                    res = '{field_code: FC_TRUNCATED, field_value: 32'd0,
                            final_result: 1'b1};
                end
            end
        end

        if (item.end_of_message)
        begin
            phase_next   = PH_HEADER;
            idx_next     = 3'd0;
            acc_next     = 32'd0;
            hdr_next     = 3'd0;
            label_next   = 8'd0;
            answers_next = 1'b0;
            atype_next   = AT_OTHER;
            rd_next      = 5'd0;
            cnt_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            idx_reg     <= 3'd0;
            acc_reg     <= 32'd0;
            hdr_reg     <= 3'd0;
            label_reg   <= 8'd0;
            answers_reg <= 1'b0;
            atype_reg   <= AT_OTHER;
            rd_reg      <= 5'd0;
            cnt_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            acc_reg     <= acc_next;
            hdr_reg     <= hdr_next;
            label_reg   <= label_next;
            answers_reg <= answers_next;
            atype_reg   <= atype_next;
            rd_reg      <= rd_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= res_valid;
        end
        else if (field_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign field_out.valid        = out_valid_reg;
    assign field_out.field_code   = out_reg.field_code;
    assign field_out.field_value  = out_reg.field_value;
    assign field_out.final_result = out_reg.final_result;

    `DNSP_ASSERT_NEXT(a_final_stops_parse, clk, rst_n,
        take && res_valid && res.final_result,
        (phase_reg == PH_IDLE) || (phase_reg == PH_HEADER),
        "final result left the parse running")
    `DNSP_ASSERT_NEXT(a_eom_rearms, clk, rst_n,
        take && item.end_of_message,
        (phase_reg == PH_HEADER) && (cnt_reg == '0) && (idx_reg == 3'd0),
        "end of message did not rearm the parser")
    `DNSP_ASSERT_NOW(a_count_bound, clk, rst_n,
        1'b1, cnt_reg <= CNT_W'(MAX_MESSAGE),
        "byte count passed the message limit")
    `DNSP_ASSERT_NOW(a_rdata_left, clk, rst_n,
        phase_reg == PH_RDATA, rd_reg != 5'd0,
        "rdata phase with no bytes left")

endmodule

[hw/rtl/dns_response_field_parser_unit.sv]
// ----------------------------------------------------------------------------
// DNS response field parser unit
// Parses a DNS response byte stream into header, question and first-answer
// field transactions.
// ----------------------------------------------------------------------------
//  channel     dir   payload                                   handshake
//  byte_in     in    msg_byte[8], end_of_message[1]            valid/ready
//  field_out   out   field_code[5], field_value[32],           valid/ready
//                    final_result[1]
//
//  One byte transaction per cycle while field_out is not stalled; a byte is
//  held in the input register, then its result, if any, in the result register.
//  Reset returns the parser to the header phase of a fresh message.
//  A stall on field_out holds the result register; the input register keeps
//  taking bytes while the parse step can still write the result register.
// ----------------------------------------------------------------------------
module dns_response_field_parser_unit
    import dnsp_pkg::*;
#(
    parameter int MAX_MESSAGE = 512
)
(
    input  logic         clk,
    input  logic         rst_n,
    dnsp_byte_if.sink    byte_in,
    dnsp_field_if.source field_out
);

    logic       take;
    logic       item_valid;
    byte_item_t item;

    dnsp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dnsp_step #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .field_out  (field_out)
    );

endmodule
